// File: design/lagr_pkg.sv
// Shared types and constants for the Lagrange interpolation evaluator.
// Depends on nothing; used by the controller, datapath and top level.
package lagr_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;
   // width of an exact difference of two 32-bit values
   localparam int DIFF_W         = 33;

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_EVAL   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_DUP   = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_OVF   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUP_RD,
      ST_DUP_CMP,
      ST_TERM_RD,
      ST_TERM_LD,
      ST_J,
      ST_J_WAIT,
      ST_DIV,
      ST_MUL,
      ST_MUL2,
      ST_ADD,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic append;
      logic start;
      logic dup_next;
      logic dup_found;
      logic term_init;
      logic term_load;
      logic j_next;
      logic div_start;
      logic mul;
      logic mul_done;
      logic add;
      logic i_next;
      logic finish;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic n_zero;
      logic n_one;
      logic dup_eq;
      logic dup_last;
      logic j_is_i;
      logic j_last;
      logic i_last;
      logic div_busy;
   } dstat_type;

endpackage

// File: design/lagr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by the datapath.
module lagr_div #(
   parameter int DW = 49,
   parameter int VW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CNT_W = $clog2(DW + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [DW-1:0]    dvd_ff;
   logic [VW-1:0]    rem_ff;
   logic [VW-1:0]    div_ff;
   logic [VW:0]      sh;
   logic             ge;
   logic [VW:0]      rem_in;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      sh     = {rem_ff, dvd_ff[DW-1]};
      ge     = sh >= {1'b0, div_ff};
      rem_in = ge ? sh - {1'b0, div_ff} : sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(DW);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (cnt_ff != '0) begin
         dvd_ff <= {dvd_ff[DW-2:0], ge};
         rem_ff <= rem_in[VW-1:0];
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = dvd_ff;

endmodule

// File: design/lagr_dp.sv
// Datapath: point stores, index counters, divider, multiplier and accumulator.
// Depends on lagr_pkg and lagr_div.
module lagr_dp #(
   parameter int MAX_POINTS = lagr_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS  = lagr_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lagr_pkg::cmd_type       cmd,
   output lagr_pkg::dstat_type     dstat,
   input  logic signed [31:0]      req_x_value,
   input  logic signed [31:0]      req_y_value,
   output logic signed [31:0]      rsp_interpolated,
   output logic [1:0]              rsp_status,
   output logic                    rsp_saturated
);
   localparam int CW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int VW = lagr_pkg::DIFF_W;
   localparam int DW = VW + FRAC_BITS;
   localparam int PW = 64 - FRAC_BITS;

   logic [31:0] xmem [MAX_POINTS];
   logic [31:0] ymem [MAX_POINTS];

   logic [NW-1:0]        count_ff;
   logic [NW-1:0]        count_m1;
   logic                 ovf_ff;
   logic [CW-1:0]        i_ff;
   logic [CW-1:0]        j_ff;
   logic signed [31:0]   z_ff;
   logic signed [31:0]   xi_ff;
   logic signed [31:0]   v_ff;
   logic signed [31:0]   sum_ff;
   logic                 sat_ff;
   lagr_pkg::status_type status_ff;
   logic                 qneg_ff;
   logic                 pneg_ff;
   logic [63:0]          prod_ff;
   logic signed [31:0]   xa_q;
   logic signed [31:0]   xb_q;
   logic signed [31:0]   y_q;
   logic signed [31:0]   out_val_ff;
   lagr_pkg::status_type out_stat_ff;
   logic                 out_sat_ff;

   logic [VW-1:0] num, den, nmag, dmag;
   logic          div_start, div_busy;
   logic [DW-1:0] quot, qlim;
   logic          q_sat;
   logic [31:0]   qmag, vmag, pm;
   logic [PW-1:0] p, plim;
   logic          p_sat;
   logic [32:0]   s33;
   logic          s_sat;
   logic signed [31:0] s_val;

   // store writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.append && (count_ff < NW'(MAX_POINTS))) begin
         xmem[count_ff[CW-1:0]] <= req_x_value;
         ymem[count_ff[CW-1:0]] <= req_y_value;
      end
      xa_q <= xmem[i_ff];
      xb_q <= xmem[j_ff];
      y_q  <= ymem[i_ff];
   end

   // fill count and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.finish) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.append) begin
         if (count_ff < NW'(MAX_POINTS)) begin
            count_ff <= count_ff + 1'b1;
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // differences and their magnitudes
   always_comb begin
      num  = {z_ff[31], z_ff} - {xb_q[31], xb_q};
      den  = {xi_ff[31], xi_ff} - {xb_q[31], xb_q};
      nmag = num[VW-1] ? (~num + 1'b1) : num;
      dmag = den[VW-1] ? (~den + 1'b1) : den;
   end

   assign div_start = cmd.div_start;

   lagr_div #(.DW(DW), .VW(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({nmag, FRAC_BITS'(0)}),
      .divisor  (dmag),
      .busy     (div_busy),
      .quotient (quot)
   );

   // saturate quotient, product and sum
   always_comb begin
      qlim  = qneg_ff ? DW'(64'h8000_0000) : DW'(64'h7fff_ffff);
      q_sat = quot > qlim;
      qmag  = q_sat ? qlim[31:0] : quot[31:0];
      vmag  = v_ff[31] ? (~v_ff + 1'b1) : v_ff;
      p     = prod_ff[63:FRAC_BITS];
      plim  = pneg_ff ? PW'(64'h8000_0000) : PW'(64'h7fff_ffff);
      p_sat = p > plim;
      pm    = p_sat ? plim[31:0] : p[31:0];
      s33   = {sum_ff[31], sum_ff} + {v_ff[31], v_ff};
      s_sat = s33[32] != s33[31];
      s_val = s_sat ? (s33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : s33[31:0];
   end

   // indices, term value and accumulator
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         z_ff      <= req_x_value;
         i_ff      <= '0;
         j_ff      <= CW'(1);
         sum_ff    <= '0;
         sat_ff    <= 1'b0;
         status_ff <= (count_ff == '0) ? lagr_pkg::STAT_EMPTY : lagr_pkg::STAT_OK;
      end
      if (cmd.dup_found) begin
         status_ff <= lagr_pkg::STAT_DUP;
      end
      if (cmd.dup_next) begin
         if (dstat.j_last) begin
            i_ff <= i_ff + 1'b1;
            j_ff <= CW'(i_ff + 2'd2);
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
      if (cmd.term_init) begin
         i_ff <= '0;
      end
      if (cmd.term_load) begin
         v_ff  <= y_q;
         xi_ff <= xa_q;
         j_ff  <= '0;
      end
      if (cmd.j_next) begin
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.div_start) begin
         qneg_ff <= num[VW-1] ^ den[VW-1];
      end
      if (cmd.mul) begin
         prod_ff <= 64'(vmag) * 64'(qmag);
         pneg_ff <= v_ff[31] ^ qneg_ff;
         if (q_sat) sat_ff <= 1'b1;
      end
      if (cmd.mul_done) begin
         v_ff <= pneg_ff ? (~pm + 1'b1) : pm;
         if (p_sat) sat_ff <= 1'b1;
      end
      if (cmd.add) begin
         sum_ff <= s_val;
         if (s_sat) sat_ff <= 1'b1;
      end
      if (cmd.i_next) begin
         i_ff <= i_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (status_ff == lagr_pkg::STAT_OK) begin
            out_val_ff  <= sum_ff;
            out_sat_ff  <= sat_ff;
            out_stat_ff <= ovf_ff ? lagr_pkg::STAT_OVF : lagr_pkg::STAT_OK;
         end else begin
            out_val_ff  <= '0;
            out_sat_ff  <= 1'b0;
            out_stat_ff <= status_ff;
         end
      end
   end

   assign count_m1         = count_ff - 1'b1;
   assign dstat.n_zero     = count_ff == '0;
   assign dstat.n_one      = count_ff == NW'(1);
   assign dstat.dup_eq     = xa_q == xb_q;
   assign dstat.dup_last   = dstat.j_last && (NW'(i_ff) == NW'(count_ff - 2'd2));
   assign dstat.j_is_i     = i_ff == j_ff;
   assign dstat.j_last     = NW'(j_ff) == count_m1;
   assign dstat.i_last     = NW'(i_ff) == count_m1;
   assign dstat.div_busy   = div_busy;
   assign rsp_interpolated = out_val_ff;
   assign rsp_status       = out_stat_ff;
   assign rsp_saturated    = out_sat_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(MAX_POINTS))
      else $error("fill count beyond store depth");
   a_finish_clr: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (count_ff == '0) && !ovf_ff)
      else $error("store not cleared after evaluate");

endmodule

// File: design/lagr_ctrl.sv
// Controller state machine sequencing the duplicate check and the term loops.
// Depends on lagr_pkg.
module lagr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lagr_pkg::cmd_type   cmd,
   input  lagr_pkg::dstat_type dstat
);
   lagr_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lagr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      acc          = 1'b0;
      unique case (state_ff)
         lagr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            acc       = req_valid;
            if (acc) begin
               if (req_opcode == lagr_pkg::OP_APPEND) begin
                  cmd.append = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  if (dstat.n_zero)     state_in = lagr_pkg::ST_FINISH;
                  else if (dstat.n_one) state_in = lagr_pkg::ST_TERM_RD;
                  else                  state_in = lagr_pkg::ST_DUP_RD;
               end
            end
         end
         lagr_pkg::ST_DUP_RD: state_in = lagr_pkg::ST_DUP_CMP;
         lagr_pkg::ST_DUP_CMP: begin
            if (dstat.dup_eq) begin
               cmd.dup_found = 1'b1;
               state_in      = lagr_pkg::ST_FINISH;
            end else if (dstat.dup_last) begin
               cmd.term_init = 1'b1;
               state_in      = lagr_pkg::ST_TERM_RD;
            end else begin
               cmd.dup_next = 1'b1;
               state_in     = lagr_pkg::ST_DUP_RD;
            end
         end
         lagr_pkg::ST_TERM_RD: state_in = lagr_pkg::ST_TERM_LD;
         lagr_pkg::ST_TERM_LD: begin
            cmd.term_load = 1'b1;
            state_in      = lagr_pkg::ST_J;
         end
         lagr_pkg::ST_J: begin
            if (!dstat.j_is_i)     state_in = lagr_pkg::ST_J_WAIT;
            else if (dstat.j_last) state_in = lagr_pkg::ST_ADD;
            else                   cmd.j_next = 1'b1;
         end
         lagr_pkg::ST_J_WAIT: begin
            cmd.div_start = 1'b1;
            state_in      = lagr_pkg::ST_DIV;
         end
         lagr_pkg::ST_DIV: begin
            if (!dstat.div_busy) begin
               cmd.mul  = 1'b1;
               state_in = lagr_pkg::ST_MUL;
            end
         end
         lagr_pkg::ST_MUL: state_in = lagr_pkg::ST_MUL2;
         lagr_pkg::ST_MUL2: begin
            cmd.mul_done = 1'b1;
            if (dstat.j_last) begin
               state_in = lagr_pkg::ST_ADD;
            end else begin
               cmd.j_next = 1'b1;
               state_in   = lagr_pkg::ST_J;
            end
         end
         lagr_pkg::ST_ADD: begin
            cmd.add = 1'b1;
            if (dstat.i_last) begin
               state_in = lagr_pkg::ST_FINISH;
            end else begin
               cmd.i_next = 1'b1;
               state_in   = lagr_pkg::ST_TERM_RD;
            end
         end
         lagr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = lagr_pkg::ST_IDLE;
            end
         end
         default: state_in = lagr_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_mul_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lagr_pkg::ST_MUL) |-> !dstat.div_busy)
      else $error("multiply issued while divider busy");
   a_eval_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == lagr_pkg::OP_EVAL)
      |=> state_ff != lagr_pkg::ST_IDLE)
      else $error("evaluate transfer did not start sequencing");
   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

endmodule

// File: design/lagrange_interpolation_eval.sv
// Top level of the Lagrange interpolation evaluator: controller plus datapath.
// Depends on lagr_pkg, lagr_ctrl, lagr_dp (and lagr_div through the datapath).
//
//   channel  ports                                        direction
//   req      req_valid/ready, opcode, x_value, y_value    in
//   rsp      rsp_valid/ready, interpolated, status, sat.  out
//
// An evaluate holds the block from its transfer to result valid, plus any wait
// for the result register; the bit-serial divider, run once per ordered pair of
// distinct points, dominates. Synchronous active-high reset empties the store.
// Input is held off while an evaluate runs; a finished result waits in its
// register while appends continue to be taken.
module lagrange_interpolation_eval #(
   parameter int MAX_POINTS = lagr_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS  = lagr_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_interpolated,
   output logic [1:0]         rsp_status,
   output logic               rsp_saturated
);
   lagr_pkg::cmd_type   cmd;
   lagr_pkg::dstat_type dstat;

   lagr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .dstat      (dstat)
   );

   lagr_dp #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .dstat            (dstat),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .rsp_interpolated (rsp_interpolated),
      .rsp_status       (rsp_status),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

// File: bench/lagrange_interpolation_eval_checker.sv
// Checker for the Lagrange evaluator: watches both channels, keeps its own
// copy of the point store and predicts every result. Depends on lagr_pkg.
module lagrange_interpolation_eval_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_opcode,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_interpolated,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_saturated,
   output int                 error_count,
   output int                 pending
);
   localparam int NPTS = lagr_pkg::MAX_POINTS_DEF;
   localparam int FRAC = lagr_pkg::FRAC_BITS_DEF;
   localparam longint MAXV = 64'sd2147483647;
   localparam longint MINV = -64'sd2147483648;

   typedef struct {
      logic signed [31:0]   value;
      lagr_pkg::status_type status;
      logic                 sat;
   } interp_result_type;

   longint            pt_x [NPTS];
   longint            pt_y [NPTS];
   int                pt_count;
   bit                dropped;
   interp_result_type expected_q[$];

   assign pending = expected_q.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic logic [63:0] magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // rebuild from sign and magnitude, clamping to 32 bits
   function automatic longint clamp(input bit neg, input logic [63:0] mag, inout bit flag);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            flag = 1;
            return MINV;
         end
         return -longint'(mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         flag = 1;
         return MAXV;
      end
      return longint'(mag);
   endfunction

   function automatic longint q_div(input longint num, input longint den, inout bit flag);
      logic [63:0] q;
      q = (magnitude(num) << FRAC) / magnitude(den);
      return clamp((num < 0) != (den < 0), q, flag);
   endfunction

   function automatic longint q_mul(input longint a, input longint b, inout bit flag);
      logic [63:0] p;
      p = (magnitude(a) * magnitude(b)) >> FRAC;
      return clamp((a < 0) != (b < 0), p, flag);
   endfunction

   // evaluate the polynomial over the stored points at z
   function automatic interp_result_type interpolate(input longint z);
      interp_result_type r;
      longint sum, term, quo;
      bit sat;
      bit dup;
      sum = 0;
      sat = 0;
      dup = 0;
      for (int i = 0; i < pt_count; i++)
         for (int j = i + 1; j < pt_count; j++)
            if (pt_x[i] == pt_x[j]) dup = 1;
      if (pt_count == 0) begin
         r.value = '0; r.status = lagr_pkg::STAT_EMPTY; r.sat = 0;
      end else if (dup) begin
         r.value = '0; r.status = lagr_pkg::STAT_DUP; r.sat = 0;
      end else begin
         for (int i = 0; i < pt_count; i++) begin
            term = pt_y[i];
            for (int j = 0; j < pt_count; j++)
               if (j != i) begin
                  quo  = q_div(z - pt_x[j], pt_x[i] - pt_x[j], sat);
                  term = q_mul(term, quo, sat);
               end
            sum = sum + term;
            if (sum > MAXV) begin sum = MAXV; sat = 1; end
            if (sum < MINV) begin sum = MINV; sat = 1; end
         end
         r.value  = sum[31:0];
         r.status = dropped ? lagr_pkg::STAT_OVF : lagr_pkg::STAT_OK;
         r.sat    = sat;
      end
      return r;
   endfunction

   // sample on the falling edge ahead of the rising edge at which a transfer happens
   always @(negedge clock) begin
      interp_result_type want;
      if (reset) begin
         pt_count    = 0;
         dropped     = 0;
         error_count = 0;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (lagr_pkg::opcode_type'(req_opcode) == lagr_pkg::OP_APPEND) begin
               if (pt_count < NPTS) begin
                  pt_x[pt_count] = req_x_value;
                  pt_y[pt_count] = req_y_value;
                  pt_count++;
               end else begin
                  dropped = 1;
               end
            end else begin
               expected_q.push_back(interpolate(req_x_value));
               pt_count = 0;
               dropped  = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected result", rsp_interpolated, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_interpolated !== want.value)
                  report("interpolated", rsp_interpolated, want.value);
               if (rsp_status !== want.status)
                  report("status", rsp_status, want.status);
               if (rsp_saturated !== want.sat)
                  report("saturated", rsp_saturated, want.sat);
            end
         end
      end
   end

endmodule

// File: bench/lagrange_interpolation_eval_tb.sv
// Top of the Lagrange evaluator testbench: clock, reset, stimulus and verdict.
// Depends on lagr_pkg, lagrange_interpolation_eval and the checker module.
module lagrange_interpolation_eval_tb;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_opcode;
   logic signed [31:0] req_x_value;
   logic signed [31:0] req_y_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_interpolated;
   logic [1:0]         rsp_status;
   logic               rsp_saturated;
   int                 error_count;
   int                 pending;
   int                 burst_left;
   int                 items_sent;
   int                 fills_left;
   int                 rx_cycle;

   lagrange_interpolation_eval u_top (.*);

   lagrange_interpolation_eval_checker u_checker (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // receiver: shifting stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         rx_cycle  <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle >= 20000 && rx_cycle < 26000)
            rsp_ready <= 0;
         else
            case ((rx_cycle >> 9) % 3)
               0: rsp_ready <= 1;
               1: rsp_ready <= $urandom_range(0, 1);
               default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
      end
   end

   // offer one item in bursts; returns at the edge of its transfer
   task automatic send_item(input lagr_pkg::opcode_type op, input logic [31:0] x,
                            input logic [31:0] y);
      bit rdy;
      if (burst_left == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
      req_valid   <= 1;
      req_opcode  <= op;
      req_x_value <= x;
      req_y_value <= y;
      do begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
      burst_left--;
      items_sent++;
   endtask

   // mostly small integers with a random fraction, sometimes any 32-bit value
   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return (($urandom_range(0, 16) - 8) << 16) + $urandom_range(0, 16'hFFFF);
   endfunction

   initial begin
      int n;
      logic [31:0] base;
      reset = 1;
      req_valid = 0;
      req_opcode = lagr_pkg::OP_APPEND;
      req_x_value = '0;
      req_y_value = '0;
      burst_left = 0;
      items_sent = 0;
      fills_left = 2;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty store
      send_item(lagr_pkg::OP_EVAL, 32'h0001_0000, 32'hFFFF_FFFF);
      // single point at the extremes
      send_item(lagr_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(lagr_pkg::OP_EVAL, 32'h7FFF_FFFF, 32'h0);
      // two extreme abscissas, forcing saturation
      send_item(lagr_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(lagr_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(lagr_pkg::OP_EVAL, 32'h8000_0000, 32'h0);
      send_item(lagr_pkg::OP_APPEND, 32'h0, 32'h7FFF_FFFF);
      send_item(lagr_pkg::OP_APPEND, 32'h0000_0001, 32'h7FFF_FFFF);
      send_item(lagr_pkg::OP_EVAL, 32'h7FFF_FFFF, 32'h0);
      // duplicate abscissa
      send_item(lagr_pkg::OP_APPEND, 32'h0002_0000, 32'h0001_0000);
      send_item(lagr_pkg::OP_APPEND, 32'h0003_0000, 32'h0005_0000);
      send_item(lagr_pkg::OP_APPEND, 32'h0002_0000, 32'h0009_0000);
      send_item(lagr_pkg::OP_EVAL, 32'h0001_0000, 32'h0);
      // three integer points evaluated between samples, then two evaluated at a sample
      send_item(lagr_pkg::OP_APPEND, 32'hFFFF_0000, 32'h0001_0000);
      send_item(lagr_pkg::OP_APPEND, 32'h0000_0000, 32'h0000_0000);
      send_item(lagr_pkg::OP_APPEND, 32'h0001_0000, 32'h0001_0000);
      send_item(lagr_pkg::OP_EVAL, 32'h0000_8000, 32'h0);
      send_item(lagr_pkg::OP_APPEND, 32'h0001_0000, 32'h0004_0000);
      send_item(lagr_pkg::OP_APPEND, 32'h0002_0000, 32'hFFF8_0000);
      send_item(lagr_pkg::OP_EVAL, 32'h0002_0000, 32'hFFFF_FFFF);

      // random data sets, a couple of them overflowing the store
      while (items_sent < 850) begin
         if (fills_left > 0 && $urandom_range(0, 60) == 0) begin
            base = $urandom;
            n = $urandom_range(65, 67);
            for (int k = 0; k < n; k++)
               send_item(lagr_pkg::OP_APPEND,
                         (fills_left == 1 && k == 40) ? base : base + (k << 12),
                         pick_value());
            fills_left--;
         end else begin
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
               send_item(lagr_pkg::OP_APPEND, pick_value(), pick_value());
         end
         send_item(lagr_pkg::OP_EVAL, pick_value(), $urandom);
      end
      req_valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #40000000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
design/lagr_pkg.sv
design/lagr_div.sv
design/lagr_dp.sv
design/lagr_ctrl.sv
design/lagrange_interpolation_eval.sv
bench/lagrange_interpolation_eval_checker.sv
bench/lagrange_interpolation_eval_tb.sv
